FILE: design/circular_deque_assert.svh
// Assertion macros for the circular deque.
// CDQ_ASSERT_IMP checks that cons holds in the cycle where ante holds.
// CDQ_ASSERT_NXT checks that cons holds in the cycle after ante holds.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque assertion failed");
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  // Capacity of the store; must be a power of two.
  localparam int DEPTH     = 1024;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;
  localparam int OUT_CNT_W = 11;

  localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;    // capture a new request
    logic update;  // apply the request to pointers, count and store
    logic rd;      // read the head and tail entries
  } cmd_t;

  typedef struct packed {
    logic drop;    // the captured request would be ignored
  } status_t;

endpackage

FILE: design/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
        // A dropped request leaves the store untouched, so the last read holds.
        state_nxt  = status.drop ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        busy      = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/cdq_datapath.sv
`timescale 1ns / 1ps
`include "circular_deque_assert.svh"

module cdq_datapath
  import cdq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic        [1:0]           in_mode,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic signed [VAL_W-1:0]     out_front_value,
  output logic signed [VAL_W-1:0]     out_back_value,
  output logic                        out_empty_flag,
  output logic        [OUT_CNT_W-1:0] out_entry_count,
  output logic                        out_ignored
);

  logic [VAL_W-1:0] mem [DEPTH];

  mode_t            mode_r;
  logic [VAL_W-1:0] value_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r;
  logic [VAL_W-1:0] rd_front_r, rd_back_r;

  logic             is_push;
  logic             is_full;
  logic             no_entries;
  logic             we;
  logic [IDX_W-1:0] waddr;

  always_comb begin
    is_push     = mode_r inside {MODE_PUSH_FRONT, MODE_PUSH_BACK};
    is_full     = (count_r == CNT_W'(DEPTH));
    no_entries  = (count_r == '0);
    status.drop = is_push ? is_full : no_entries;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = '0;
    if (!status.drop) begin
      case (mode_r)
        MODE_PUSH_FRONT: begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
          if (no_entries) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = head_r - 1'b1;
          end
          waddr = head_nxt;
        end
        MODE_PUSH_BACK: begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
          if (no_entries) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            tail_nxt = tail_r + 1'b1;
          end
          waddr = tail_nxt;
        end
        MODE_POP_FRONT: begin
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = head_r + 1'b1;
          end
        end
        MODE_POP_BACK: begin
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            tail_nxt = tail_r - 1'b1;
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.update) begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      dropped_r <= status.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode_t'(in_mode);
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && we) begin
      mem[waddr] <= value_r;
    end
    if (cmd.rd) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[tail_r];
    end
  end

  assign out_empty_flag  = no_entries;
  assign out_front_value = no_entries ? EMPTY_MARK : rd_front_r;
  assign out_back_value  = no_entries ? EMPTY_MARK : rd_back_r;
  assign out_entry_count = OUT_CNT_W'(count_r);
  assign out_ignored     = dropped_r;

  `CDQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `CDQ_ASSERT_IMP(a_empty_ptrs, clk, rst_n, no_entries, (head_r == '0) && (tail_r == '0))
  `CDQ_ASSERT_NXT(a_drop_holds, clk, rst_n, cmd.update && status.drop,
                  $stable(count_r) && $stable(head_r) && $stable(tail_r))
  `CDQ_ASSERT_NXT(a_take_moves, clk, rst_n, cmd.update && !status.drop,
                  count_r != $past(count_r))

endmodule

FILE: design/circular_deque.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload ports
// request   start / busy           in_mode, in_value
// result    out_valid (strobe)     out_front_value, out_back_value, out_empty_flag,
//                                  out_entry_count, out_ignored
//
// A request is taken at a clock edge where start is high and busy is low.
// Each request passes through an update of pointers, count and store, then
// the registered two-port read of the head and tail entries, and then a state
// in which the result is shown; a dropped request skips the read. The store has
// a single write port and a registered read.
// Reset is synchronous and active low; it clears pointers, count and control,
// while the store contents stay undefined until written. The receiver cannot
// stall, and a new request may be taken in the same cycle a result is shown.

module circular_deque
  import cdq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic        [1:0]           in_mode,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic                        out_valid,
  output logic signed [VAL_W-1:0]     out_front_value,
  output logic signed [VAL_W-1:0]     out_back_value,
  output logic                        out_empty_flag,
  output logic        [OUT_CNT_W-1:0] out_entry_count,
  output logic                        out_ignored
);

  // The controller sequences each request; the datapath holds the pointers,
  // the count and the circular store, and tells the controller whether the
  // current request would be ignored.
  cmd_t    cmd;
  status_t status;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Count, empty and ignored fields hold from each update, front and back values
  // from each read, until replaced, so they are valid whenever the strobe is high.
  cdq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_empty_flag  (out_empty_flag),
    .out_entry_count (out_entry_count),
    .out_ignored     (out_ignored)
  );

endmodule
